@@ hw/rtl/e1904_pkg.sv @@
// Shared constants, types and month table for the 1904-epoch timestamp converter.
package e1904_pkg;

    localparam int NUM_STAGES = 8;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned DAYS_PER_CYC  = 1461;
    localparam int unsigned DAYS_LEAP     = 366;
    localparam int unsigned DAYS_YEAR     = 365;
    localparam int unsigned EPOCH_YEAR    = 1904;

    // Reciprocals for constant division: seconds/128/675, days/1461,
    // seconds-of-day/16/225 and minute-seconds/4/15
    localparam int unsigned DAY_RECIP   = 50903316;
    localparam int unsigned DAY_SHIFT   = 35;
    localparam int unsigned CYC_RECIP   = 45934;
    localparam int unsigned HOUR_RECIP  = 4661;
    localparam int unsigned MIN_RECIP   = 1093;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] vld;
    } pipe_ctl_t;

    // First day-of-year (from 0) of month idx, 0 is January
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] base;
        logic       adj;
        base = 9'd0;
        adj  = leap && (idx >= 4'd2);
        unique case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + {8'd0, adj};
    endfunction

endpackage

@@ hw/rtl/e1904_in_if.sv @@
// Input channel: one raw timestamp word per item.
interface e1904_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_time_word;

    modport source (output valid, output raw_time_word, input ready);
    modport sink   (input valid, input raw_time_word, output ready);
endinterface

@@ hw/rtl/e1904_out_if.sv @@
// Output channel: one calendar date and time per item.
interface e1904_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    modport source (output valid, output year, output month, output day,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input year, input month, input day,
                    input hour, input minute, input second, output ready);
endinterface

@@ hw/rtl/epoch1904_seconds_to_datetime_unit.sv @@
// Eight-stage pipeline from accepted item to result valid.
// Throughput one item per cycle while the output is ready; every stage holds at most one item and
// empty stages fill while a finished result waits at the output.
// The widest step is one 25x26 multiply for the day count.
// Reset (rst_n, asynchronous, active low) clears all valid bits; data
// registers are not reset.
module epoch1904_seconds_to_datetime_unit
    import e1904_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    e1904_in_if.sink    time_in,
    e1904_out_if.source date_out
);

    pipe_ctl_t ctl;

    e1904_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (time_in.valid),
        .out_ready (date_out.ready),
        .ctl       (ctl)
    );

    assign time_in.ready  = ctl.en[0];
    assign date_out.valid = ctl.vld[NUM_STAGES-1];

    // Stage 1: reverse byte order
    logic [31:0] s1_secs_reg;
    logic [31:0] s1_secs_next;

    assign s1_secs_next = {time_in.raw_time_word[7:0], time_in.raw_time_word[15:8],
                           time_in.raw_time_word[23:16], time_in.raw_time_word[31:24]};

    // Stage 2: day estimate, may be one low
    logic [31:0] s2_secs_reg;
    logic [15:0] s2_q_reg;
    logic [50:0] s2_prod;
    logic [15:0] s2_q_next;

    assign s2_prod   = {26'd0, s1_secs_reg[31:7]} * 51'(DAY_RECIP);
    assign s2_q_next = s2_prod[50:DAY_SHIFT];

    // Stage 3: remainder against the estimate
    logic [15:0] s3_q_reg;
    logic [17:0] s3_r_reg;
    logic [32:0] s3_prod;
    logic [31:0] s3_diff;

    assign s3_prod = {17'd0, s2_q_reg} * 33'(SECS_PER_DAY);
    assign s3_diff = s2_secs_reg - s3_prod[31:0];

    // Stage 4: correct the estimate
    logic [15:0] s4_days_reg;
    logic [16:0] s4_sod_reg;
    logic [15:0] s4_days_next;
    logic [16:0] s4_sod_next;

    always_comb
    begin
        if (s3_r_reg >= 18'(SECS_PER_DAY))
        begin
            s4_days_next = s3_q_reg + 16'd1;
            s4_sod_next  = 17'(s3_r_reg - 18'(SECS_PER_DAY));
        end
        else
        begin
            s4_days_next = s3_q_reg;
            s4_sod_next  = s3_r_reg[16:0];
        end
    end

    // Stage 5: four-year cycle and hour
    logic [15:0] s5_days_reg;
    logic [16:0] s5_sod_reg;
    logic [5:0]  s5_cyc_reg;
    logic [4:0]  s5_hour_reg;
    logic [31:0] s5_cyc_prod;
    logic [25:0] s5_hour_prod;

    assign s5_cyc_prod  = {16'd0, s4_days_reg} * 32'(CYC_RECIP);
    assign s5_hour_prod = {13'd0, s4_sod_reg[16:4]} * 26'(HOUR_RECIP);

    // Stage 6: day of cycle and second of hour
    logic [5:0]  s6_cyc_reg;
    logic [4:0]  s6_hour_reg;
    logic [10:0] s6_rem_reg;
    logic [11:0] s6_ms_reg;
    logic [15:0] s6_cyc_days;
    logic [16:0] s6_hour_secs;
    logic [15:0] s6_rem_full;
    logic [16:0] s6_ms_full;

    assign s6_cyc_days  = {10'd0, s5_cyc_reg} * 16'(DAYS_PER_CYC);
    assign s6_hour_secs = {12'd0, s5_hour_reg} * 17'(SECS_PER_HOUR);
    assign s6_rem_full  = s5_days_reg - s6_cyc_days;
    assign s6_ms_full   = s5_sod_reg - s6_hour_secs;

    // Stage 7: year within cycle, day of year, minute
    logic [5:0]  s7_cyc_reg;
    logic [4:0]  s7_hour_reg;
    logic [11:0] s7_ms_reg;
    logic [1:0]  s7_yoff_reg;
    logic [8:0]  s7_doy_reg;
    logic [5:0]  s7_min_reg;
    logic [1:0]  s7_yoff_next;
    logic [8:0]  s7_doy_next;
    logic [10:0] s7_r2;
    logic [20:0] s7_min_prod;

    assign s7_r2       = s6_rem_reg - 11'(DAYS_LEAP);
    assign s7_min_prod = {11'd0, s6_ms_reg[11:2]} * 21'(MIN_RECIP);

    always_comb
    begin
        priority if (s6_rem_reg < 11'(DAYS_LEAP))
        begin
            s7_yoff_next = 2'd0;
            s7_doy_next  = s6_rem_reg[8:0];
        end
        else if (s7_r2 >= 11'(2 * DAYS_YEAR))
        begin
            s7_yoff_next = 2'd3;
            s7_doy_next  = 9'(s7_r2 - 11'(2 * DAYS_YEAR));
        end
        else if (s7_r2 >= 11'(DAYS_YEAR))
        begin
            s7_yoff_next = 2'd2;
            s7_doy_next  = 9'(s7_r2 - 11'(DAYS_YEAR));
        end
        else
        begin
            s7_yoff_next = 2'd1;
            s7_doy_next  = s7_r2[8:0];
        end
    end

    // Stage 8: month walk, year, second
    logic [10:0] s8_year_reg;
    logic [3:0]  s8_month_reg;
    logic [4:0]  s8_day_reg;
    logic [4:0]  s8_hour_reg;
    logic [5:0]  s8_min_reg;
    logic [5:0]  s8_sec_reg;
    logic        s8_leap;
    logic [3:0]  s8_midx;
    logic [8:0]  s8_day0;
    logic [11:0] s8_min_secs;
    logic [11:0] s8_sec_full;
    logic [10:0] s8_year_next;

    assign s8_leap = (s7_yoff_reg == 2'd0);

    // Take the last month whose first day is not past the day of year
    always_comb
    begin
        s8_midx = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (s7_doy_reg >= month_start(s8_leap, 4'(k)))
            begin
                s8_midx = 4'(k);
            end
        end
    end

    assign s8_day0      = s7_doy_reg - month_start(s8_leap, s8_midx);
    assign s8_min_secs  = {6'd0, s7_min_reg} * 12'(SECS_PER_MIN);
    assign s8_sec_full  = s7_ms_reg - s8_min_secs;
    assign s8_year_next = 11'(EPOCH_YEAR) + {3'd0, s7_cyc_reg, 2'b00}
                        + {9'd0, s7_yoff_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            s1_secs_reg <= s1_secs_next;
        end
        if (ctl.en[1])
        begin
            s2_secs_reg <= s1_secs_reg;
            s2_q_reg    <= s2_q_next;
        end
        if (ctl.en[2])
        begin
            s3_q_reg <= s2_q_reg;
            s3_r_reg <= s3_diff[17:0];
        end
        if (ctl.en[3])
        begin
            s4_days_reg <= s4_days_next;
            s4_sod_reg  <= s4_sod_next;
        end
        if (ctl.en[4])
        begin
            s5_days_reg <= s4_days_reg;
            s5_sod_reg  <= s4_sod_reg;
            s5_cyc_reg  <= s5_cyc_prod[31:26];
            s5_hour_reg <= s5_hour_prod[24:20];
        end
        if (ctl.en[5])
        begin
            s6_cyc_reg  <= s5_cyc_reg;
            s6_hour_reg <= s5_hour_reg;
            s6_rem_reg  <= s6_rem_full[10:0];
            s6_ms_reg   <= s6_ms_full[11:0];
        end
        if (ctl.en[6])
        begin
            s7_cyc_reg  <= s6_cyc_reg;
            s7_hour_reg <= s6_hour_reg;
            s7_ms_reg   <= s6_ms_reg;
            s7_yoff_reg <= s7_yoff_next;
            s7_doy_reg  <= s7_doy_next;
            s7_min_reg  <= s7_min_prod[19:14];
        end
        if (ctl.en[7])
        begin
            s8_year_reg  <= s8_year_next;
            s8_month_reg <= s8_midx + 4'd1;
            s8_day_reg   <= 5'(s8_day0 + 9'd1);
            s8_hour_reg  <= s7_hour_reg;
            s8_min_reg   <= s7_min_reg;
            s8_sec_reg   <= s8_sec_full[5:0];
        end
    end

    assign date_out.year   = s8_year_reg;
    assign date_out.month  = s8_month_reg;
    assign date_out.day    = s8_day_reg;
    assign date_out.hour   = s8_hour_reg;
    assign date_out.minute = s8_min_reg;
    assign date_out.second = s8_sec_reg;

`ifndef SYNTH
    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (time_in.valid && time_in.ready) |=> ctl.vld[0])
        else $error("accepted item did not reach the first stage");

    a_day_corrected: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.vld[3] |-> (s4_sod_reg < 17'(SECS_PER_DAY)))
        else $error("second of day out of range after correction");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        date_out.valid |-> (date_out.month >= 4'd1 && date_out.month <= 4'd12
                            && date_out.day >= 5'd1 && date_out.year >= 11'(EPOCH_YEAR)))
        else $error("date field out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        date_out.valid |-> (date_out.hour < 5'd24 && date_out.minute < 6'd60
                            && date_out.second < 6'd60))
        else $error("time field out of range");
`endif

endmodule

@@ hw/rtl/e1904_pipe_ctrl.sv @@
// Valid bits and per-stage load enables for the converter pipeline.
module e1904_pipe_ctrl
    import e1904_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_ready,
    output pipe_ctl_t ctl
);

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] en;

    // A stage loads when it is empty or its successor moves on
    always_comb
    begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign ctl.en  = en;
    assign ctl.vld = vld_reg;

endmodule
